FILE: hw/rtl/spimf_pkg.sv
// Shared constants, codes and types for the SPI master with FIFOs.
package spimf_pkg;

	localparam int FIFO_DEPTH_DEF = 16;
	localparam int OBUF_DEPTH = 3;
	localparam int OBUF_CW = $clog2(OBUF_DEPTH + 1);
	localparam int OBUF_IW = $clog2(OBUF_DEPTH);

	localparam logic [15:0] DIVIDER_RESET = 16'd256;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic REG_CTRL = 1'b0;
	localparam logic REG_DATA = 1'b1;

	localparam int CTRL_CLR_TX_BIT = 4;
	localparam int CTRL_CLR_RX_BIT = 5;
	localparam int CTRL_ACTIVE_BIT = 7;

	typedef struct packed {
		logic        cs1_n;
		logic        cs0_n;
		logic        mosi;
		logic        sclk;
		logic [18:0] read_data;
	} result_t;

endpackage

FILE: hw/rtl/spimf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spimf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/spimf_obuf.sv
// Small result buffer that decouples the result stream from the input stream.
module spimf_obuf (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  spimf_pkg::result_t              push_data,
	input  logic                            pop,
	output logic                            out_valid,
	output spimf_pkg::result_t              out_data,
	output logic [spimf_pkg::OBUF_CW-1:0]   count
);

	localparam logic [spimf_pkg::OBUF_IW-1:0] LAST_IDX =
		spimf_pkg::OBUF_IW'(spimf_pkg::OBUF_DEPTH - 1);

	spimf_pkg::result_t                entry_q [spimf_pkg::OBUF_DEPTH];
	logic [spimf_pkg::OBUF_IW-1:0]     wptr_q;
	logic [spimf_pkg::OBUF_IW-1:0]     rptr_q;
	logic [spimf_pkg::OBUF_CW-1:0]     count_q;

	assign out_valid = (count_q != '0);
	assign out_data = entry_q[rptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/spi_master_with_fifos_core.sv
// Top level of the mode 0 SPI master with TX and RX byte FIFOs behind registers.
//
//  Channel   | Direction | Contents
//  s_axis    | in        | tuser: kind, reg_select; tdata: write_data, miso
//  m_axis    | out       | tdata: read_data, sclk, mosi, cs0_n, cs1_n
//  cfg       | in        | clock_divider, written whenever cfg_we is high
//
// One beat is accepted every cycle while the buffer has room. Its state update
// happens in the cycle of acceptance; the FIFO memories answer in the cycle
// after, when the result is formed and placed in a three-entry result buffer
// that it leaves from. Stalls on the result side fill the buffer and then hold
// s_axis_tready low. Reset needs no clearing pass.
module spi_master_with_fifos_core #(
	parameter int FIFO_DEPTH = spimf_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] write_data, [8] miso, rest zero
	input  logic [2:0]  s_axis_tuser,  // [1:0] kind, [2] reg_select
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [18:0] read_data, [19] sclk, [20] mosi,
	                                   // [21] cs0_n, [22] cs1_n, rest zero
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int IW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);

	logic [1:0] kind;
	logic       reg_sel;
	logic [7:0] wr_data;
	logic       miso_in;
	logic       acc;

	assign kind = s_axis_tuser[1:0];
	assign reg_sel = s_axis_tuser[2];
	assign wr_data = s_axis_tdata[7:0];
	assign miso_in = s_axis_tdata[8];
	assign acc = s_axis_tvalid && s_axis_tready;

	logic [15:0]   divider_q;
	logic          active_q, active_nxt;
	logic [1:0]    csel_q, csel_nxt;
	logic [CW-1:0] tx_count_q, tx_count_nxt;
	logic [IW-1:0] tx_head_q, tx_head_nxt;
	logic [CW-1:0] rx_count_q, rx_count_nxt;
	logic [IW-1:0] rx_head_q, rx_head_nxt;
	logic [7:0]    shift_byte_q, shift_nxt;
	logic [3:0]    bits_left_q, bits_nxt;
	logic          clk_lvl_q, clk_lvl_nxt;
	logic [15:0]   div_cnt_q, div_cnt_nxt;
	logic          miso_q, miso_nxt;
	logic          load_pend_q, load_nxt;

	logic          valid_s1;
	logic [18:0]   status_s1;
	logic          pop_s1;
	logic          from_load_s1;
	logic          mosi_s1;
	logic          sclk_s1;
	logic          cs0_n_s1;
	logic          cs1_n_s1;

	logic          tx_we, tx_re, rx_we, rx_re;
	logic [IW-1:0] tx_waddr, rx_waddr;
	logic [7:0]    rx_wdata;
	logic [7:0]    tx_rdata, rx_rdata;
	logic [7:0]    sb;
	logic [SW-1:0] tx_wsum, rx_wsum, tx_hinc, rx_hinc;
	logic [IW-1:0] tx_head_inc, rx_head_inc;
	logic [15:0]   half;
	logic [15:0]   div_inc;
	logic [18:0]   status_nxt;
	logic          pop_nxt;
	logic [3:0]    bits_dec;

	always_comb begin
		tx_wsum = SW'(tx_head_q) + SW'(tx_count_q);
		rx_wsum = SW'(rx_head_q) + SW'(rx_count_q);
		tx_hinc = SW'(tx_head_q) + SW'(1);
		rx_hinc = SW'(rx_head_q) + SW'(1);
		tx_waddr = (tx_wsum >= DEPTH_S) ? IW'(tx_wsum - DEPTH_S) : IW'(tx_wsum);
		rx_waddr = (rx_wsum >= DEPTH_S) ? IW'(rx_wsum - DEPTH_S) : IW'(rx_wsum);
		tx_head_inc = (tx_hinc >= DEPTH_S) ? IW'(tx_hinc - DEPTH_S) : IW'(tx_hinc);
		rx_head_inc = (rx_hinc >= DEPTH_S) ? IW'(rx_hinc - DEPTH_S) : IW'(rx_hinc);
		half = (divider_q[15:1] == 15'd0) ? 16'h8000 : {1'b0, divider_q[15:1]};
		div_inc = div_cnt_q + 16'd1;
		sb = load_pend_q ? tx_rdata : shift_byte_q;
		bits_dec = bits_left_q - 4'd1;

		active_nxt = active_q;
		csel_nxt = csel_q;
		tx_count_nxt = tx_count_q;
		tx_head_nxt = tx_head_q;
		rx_count_nxt = rx_count_q;
		rx_head_nxt = rx_head_q;
		shift_nxt = sb;
		bits_nxt = bits_left_q;
		clk_lvl_nxt = clk_lvl_q;
		div_cnt_nxt = div_cnt_q;
		miso_nxt = miso_q;
		load_nxt = 1'b0;
		status_nxt = '0;
		pop_nxt = 1'b0;
		tx_we = 1'b0;
		tx_re = 1'b0;
		rx_we = 1'b0;
		rx_re = 1'b0;
		rx_wdata = {sb[6:0], miso_q};

		if (acc) begin
			unique case (kind)
				spimf_pkg::KIND_WRITE: begin
					if (reg_sel == spimf_pkg::REG_CTRL) begin
						csel_nxt = wr_data[1:0];
						if (wr_data[spimf_pkg::CTRL_CLR_TX_BIT]) begin
							tx_count_nxt = '0;
							tx_head_nxt = '0;
						end
						if (wr_data[spimf_pkg::CTRL_CLR_RX_BIT]) begin
							rx_count_nxt = '0;
							rx_head_nxt = '0;
						end
						active_nxt = wr_data[spimf_pkg::CTRL_ACTIVE_BIT];
						if (!wr_data[spimf_pkg::CTRL_ACTIVE_BIT]) begin
							bits_nxt = '0;
							clk_lvl_nxt = 1'b0;
							div_cnt_nxt = '0;
						end
					end else if (tx_count_q < FULL) begin
						tx_we = 1'b1;
						tx_count_nxt = tx_count_q + 1'b1;
					end
				end
				spimf_pkg::KIND_READ: begin
					if (reg_sel == spimf_pkg::REG_CTRL) begin
						status_nxt = {(tx_count_q < FULL), (rx_count_q != '0),
							((tx_count_q == '0) && (bits_left_q == '0)),
							8'd0, active_q, 5'd0, csel_q};
					end else if (rx_count_q != '0) begin
						rx_re = 1'b1;
						pop_nxt = 1'b1;
						rx_head_nxt = rx_head_inc;
						rx_count_nxt = rx_count_q - 1'b1;
					end
				end
				spimf_pkg::KIND_TICK: begin
					if (active_q) begin
						if (bits_left_q == '0) begin
							if ((tx_count_q != '0) && (rx_count_q < FULL)) begin
								tx_re = 1'b1;
								load_nxt = 1'b1;
								tx_head_nxt = tx_head_inc;
								tx_count_nxt = tx_count_q - 1'b1;
								bits_nxt = 4'd8;
								clk_lvl_nxt = 1'b0;
								div_cnt_nxt = '0;
							end
						end else if (div_inc < half) begin
							div_cnt_nxt = div_inc;
						end else begin
							div_cnt_nxt = '0;
							if (!clk_lvl_q) begin
								clk_lvl_nxt = 1'b1;
								miso_nxt = miso_in;
							end else begin
								clk_lvl_nxt = 1'b0;
								shift_nxt = {sb[6:0], miso_q};
								bits_nxt = bits_dec;
								if ((bits_dec == '0) && (rx_count_q < FULL)) begin
									rx_we = 1'b1;
									rx_count_nxt = rx_count_q + 1'b1;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	spimf_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(wr_data),
		.re   (tx_re),
		.raddr(tx_head_q),
		.rdata(tx_rdata)
	);

	spimf_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(rx_wdata),
		.re   (rx_re),
		.raddr(rx_head_q),
		.rdata(rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= spimf_pkg::DIVIDER_RESET;
			active_q <= 1'b0;
			csel_q <= '0;
			tx_count_q <= '0;
			tx_head_q <= '0;
			rx_count_q <= '0;
			rx_head_q <= '0;
			shift_byte_q <= '0;
			bits_left_q <= '0;
			clk_lvl_q <= 1'b0;
			div_cnt_q <= '0;
			miso_q <= 1'b0;
			load_pend_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				divider_q <= cfg_wdata;
			end
			active_q <= active_nxt;
			csel_q <= csel_nxt;
			tx_count_q <= tx_count_nxt;
			tx_head_q <= tx_head_nxt;
			rx_count_q <= rx_count_nxt;
			rx_head_q <= rx_head_nxt;
			shift_byte_q <= shift_nxt;
			bits_left_q <= bits_nxt;
			clk_lvl_q <= clk_lvl_nxt;
			div_cnt_q <= div_cnt_nxt;
			miso_q <= miso_nxt;
			load_pend_q <= load_nxt;
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_nxt;
			pop_s1 <= pop_nxt;
			from_load_s1 <= load_nxt;
			mosi_s1 <= (bits_nxt != '0) && shift_nxt[7];
			sclk_s1 <= clk_lvl_nxt;
			cs0_n_s1 <= !(active_nxt && (csel_nxt == 2'd0));
			cs1_n_s1 <= !(active_nxt && (csel_nxt == 2'd1));
		end
	end

	spimf_pkg::result_t            res;
	spimf_pkg::result_t            out_res;
	logic [spimf_pkg::OBUF_CW-1:0] obuf_count;
	logic                          out_pop;

	always_comb begin
		res.read_data = pop_s1 ? {11'd0, rx_rdata} : status_s1;
		res.sclk = sclk_s1;
		res.mosi = from_load_s1 ? tx_rdata[7] : mosi_s1;
		res.cs0_n = cs0_n_s1;
		res.cs1_n = cs1_n_s1;
	end

	assign out_pop = m_axis_tvalid && m_axis_tready;

	spimf_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1),
		.push_data(res),
		.pop      (out_pop),
		.out_valid(m_axis_tvalid),
		.out_data (out_res),
		.count    (obuf_count)
	);

	assign s_axis_tready = ((SW'(obuf_count) + SW'(valid_s1)) < SW'(spimf_pkg::OBUF_DEPTH));
	assign m_axis_tdata = {1'b0, out_res.cs1_n, out_res.cs0_n, out_res.mosi, out_res.sclk,
		out_res.read_data};

endmodule
